[sv/assert_macros.svh]
// Assertion macros used by the checker file bns_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: check failed");

// ante at one edge implies cons at the next edge
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[sv/bns_pkg.sv]
// Buzzer note sequencer package: word types, codes and the period table.
// No dependencies.
package bns_pkg;

  localparam int PATTERN_DEPTH = 256;
  localparam int ADDR_W        = 8;
  localparam int LEN_W         = 9;
  localparam int TICK_W        = 7;

  localparam logic [LEN_W-1:0] LENGTH_RESET = 9'd13;

  // commands
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_MODE = 2'd1;
  localparam logic [1:0] CMD_LOAD = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  // play modes
  localparam logic [1:0] MODE_STOP  = 2'd0;
  localparam logic [1:0] MODE_BOOT  = 2'd1;
  localparam logic [1:0] MODE_SONG  = 2'd2;
  localparam logic [1:0] MODE_SOUND = 2'd3;

  // sound tone codes
  localparam logic [3:0] TONE_SILENT = 4'h0;
  localparam logic [3:0] TONE_HIGH   = 4'hB;
  localparam logic [3:0] TONE_LOW    = 4'hD;

  // periods at a 1 MHz timer clock: 1000000 / f - 1
  localparam logic [11:0] PERIOD_HIGH = 12'd1561;  // 640 Hz
  localparam logic [11:0] PERIOD_LOW  = 12'd3905;  // 256 Hz

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  new_mode;
    logic [7:0]  load_index;
    logic [15:0] load_word;
  } bns_item_t;

  typedef struct packed {
    logic        drive_update;
    logic        tone_on;
    logic [11:0] period;
    logic [10:0] compare;
    logic [1:0]  mode_now;
    logic        song_done;
  } bns_result_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] pos;
    logic [TICK_W-1:0] tick;
  } bns_state_t;

  // octave 0..2, note 1..7
  function automatic logic [11:0] note_period(input logic [1:0] oct, input logic [2:0] note);
    logic [11:0] p;
    p = 12'd0;
    case ({oct, note})
      {2'd0, 3'd1}: p = 12'd3815;
      {2'd0, 3'd2}: p = 12'd3400;
      {2'd0, 3'd3}: p = 12'd3029;
      {2'd0, 3'd4}: p = 12'd2864;
      {2'd0, 3'd5}: p = 12'd2550;
      {2'd0, 3'd6}: p = 12'd2271;
      {2'd0, 3'd7}: p = 12'd2023;
      {2'd1, 3'd1}: p = 12'd1911;
      {2'd1, 3'd2}: p = 12'd1702;
      {2'd1, 3'd3}: p = 12'd1516;
      {2'd1, 3'd4}: p = 12'd1431;
      {2'd1, 3'd5}: p = 12'd1274;
      {2'd1, 3'd6}: p = 12'd1135;
      {2'd1, 3'd7}: p = 12'd1011;
      {2'd2, 3'd1}: p = 12'd955;
      {2'd2, 3'd2}: p = 12'd850;
      {2'd2, 3'd3}: p = 12'd757;
      {2'd2, 3'd4}: p = 12'd714;
      {2'd2, 3'd5}: p = 12'd636;
      {2'd2, 3'd6}: p = 12'd567;
      {2'd2, 3'd7}: p = 12'd505;
      default:      p = 12'd0;
    endcase
    return p;
  endfunction

endpackage

[sv/bns_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/bns_step.sv]
// Per-word sequencing logic: next state and result word for one item.
// Depends on bns_pkg.
module bns_step (
  input  bns_pkg::bns_item_t   item,
  input  bns_pkg::bns_state_t  cur,
  input  logic [15:0]          pword,
  input  logic [8:0]           len,
  output bns_pkg::bns_state_t  nxt,
  output bns_pkg::bns_result_t res
);

  logic [6:0] on_t;
  logic [6:0] song_end;
  logic [6:0] dur;
  logic [8:0] pos_inc;
  logic       wrap;
  logic       note_ok;
  logic [11:0] note_p;

  always_comb begin
    on_t     = 7'(pword[11:8]) * 7'd6;
    song_end = on_t + 7'(pword[15:12]);
    dur      = {2'b00, pword[7:4], 1'b0};
    pos_inc  = {1'b0, cur.pos} + 9'd1;
    wrap     = pos_inc >= len;
    note_ok  = (pword[7:4] <= 4'd2) && (pword[3:0] >= 4'd1) && (pword[3:0] <= 4'd7);
    note_p   = bns_pkg::note_period(pword[5:4], pword[2:0]);
  end

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (item.cmd)
      bns_pkg::CMD_TICK: begin
        if (cur.mode == bns_pkg::MODE_BOOT || cur.mode == bns_pkg::MODE_SONG) begin
          if (cur.tick < on_t) begin
            nxt.tick = cur.tick + 7'd1;
            res.drive_update = 1'b1;
            if (note_ok) begin
              res.tone_on = 1'b1;
              res.period  = note_p;
              res.compare = note_p[11:1];
            end
          end else if (cur.tick < song_end) begin
            nxt.tick = cur.tick + 7'd1;
            res.drive_update = 1'b1;
          end else begin
            nxt.tick = 7'd1;
            nxt.pos  = pos_inc[7:0];
            if (wrap) begin
              // end of song: stop and silence
              nxt.pos          = '0;
              nxt.mode         = bns_pkg::MODE_STOP;
              res.drive_update = 1'b1;
              res.song_done    = 1'b1;
            end
          end
        end else if (cur.mode == bns_pkg::MODE_SOUND) begin
          if (cur.tick < dur) begin
            nxt.tick = cur.tick + 7'd1;
            case (pword[3:0])
              bns_pkg::TONE_SILENT: res.drive_update = 1'b1;
              bns_pkg::TONE_HIGH: begin
                res.drive_update = 1'b1;
                res.tone_on      = 1'b1;
                res.period       = bns_pkg::PERIOD_HIGH;
                res.compare      = bns_pkg::PERIOD_HIGH[11:1];
              end
              bns_pkg::TONE_LOW: begin
                res.drive_update = 1'b1;
                res.tone_on      = 1'b1;
                res.period       = bns_pkg::PERIOD_LOW;
                res.compare      = bns_pkg::PERIOD_LOW[11:1];
              end
              default: ;  // timer left as is
            endcase
          end else begin
            // sound patterns loop
            nxt.tick = 7'd1;
            nxt.pos  = wrap ? '0 : pos_inc[7:0];
          end
        end
      end
      bns_pkg::CMD_MODE: begin
        // locked start-up song ignores mode changes
        if (cur.mode != bns_pkg::MODE_BOOT) begin
          nxt.mode = item.new_mode;
          nxt.pos  = '0;
          nxt.tick = 7'd1;
          if (item.new_mode == bns_pkg::MODE_STOP) begin
            res.drive_update = 1'b1;
          end
        end
      end
      bns_pkg::CMD_LOAD: ;  // memory write happens at acceptance
      bns_pkg::CMD_NONE: ;
      default: ;
    endcase
    res.mode_now = nxt.mode;
  end

endmodule

[sv/buzzer_note_sequencer_unit.sv]
// Stage 1 holds a word during its pattern read; the output register holds
// its result. Throughput: one word per cycle unless stalled; the pattern
// memory is read at acceptance at the position forwarded by the word ahead.
// Reset (rst, synchronous): stopped, position 0, tick count 1, length 13.
// Pattern memory is not cleared; entries are undefined until loaded.
// Depends on bns_pkg, bns_ram, bns_step.
module buzzer_note_sequencer_unit (
  input  logic                 clk,
  input  logic                 rst,
  // item channel
  input  logic                 item_valid,
  output logic                 item_stall,
  input  bns_pkg::bns_item_t   item,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output bns_pkg::bns_result_t result,
  // pattern length register write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [8:0]           cfg_data
);

  // Stage 1 holds the accepted word while its pattern entry is read.
  logic               s1_valid;
  bns_pkg::bns_item_t s1_item;

  // Play state; updated when stage 1 hands its result to the output.
  bns_pkg::bns_state_t state;
  bns_pkg::bns_state_t state_fwd;
  bns_pkg::bns_state_t step_next;
  bns_pkg::bns_result_t step_res;

  logic [8:0]  pattern_length;
  logic [8:0]  eff_len;
  logic [15:0] pword;

  logic out_free;
  logic adv;
  logic accept;

  // Output register is free when empty or being drained this cycle.
  assign out_free   = !result_valid || !result_stall;
  assign adv        = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;

  // Length clamp: zero acts as one, above the memory depth acts as the depth.
  always_comb begin
    if (pattern_length == 9'd0) begin
      eff_len = 9'd1;
    end else if (pattern_length > 9'(bns_pkg::PATTERN_DEPTH)) begin
      eff_len = 9'(bns_pkg::PATTERN_DEPTH);
    end else begin
      eff_len = pattern_length;
    end
  end

  // Forward the state left by the word in stage 1 so the next read
  // uses the right position.
  assign state_fwd = adv ? step_next : state;

  // Loads write at acceptance; every accepted word starts a read. A load
  // never uses its own read data, so read-during-write order is moot.
  bns_ram #(
    .WIDTH (16),
    .DEPTH (bns_pkg::PATTERN_DEPTH)
  ) u_pattern_ram (
    .clk     (clk),
    .wr_en   (accept && item.cmd == bns_pkg::CMD_LOAD),
    .wr_addr (item.load_index),
    .wr_data (item.load_word),
    .rd_en   (accept),
    .rd_addr (state_fwd.pos),
    .rd_data (pword)
  );

  bns_step u_step (
    .item  (s1_item),
    .cur   (state),
    .pword (pword),
    .len   (eff_len),
    .nxt   (step_next),
    .res   (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      result_valid   <= 1'b0;
      state.mode     <= bns_pkg::MODE_STOP;
      state.pos      <= '0;
      state.tick     <= 7'd1;
      pattern_length <= bns_pkg::LENGTH_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pattern_length <= cfg_data;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        state        <= step_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
    if (adv) begin
      result <= step_res;
    end
  end

endmodule

[sv/bns_checker.sv]
// Port-level checks for the buzzer note sequencer, bound to the top level.
// Depends on bns_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bns_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 result_valid,
  input logic                 result_stall,
  input bns_pkg::bns_result_t result
);

  logic silent_ok;
  logic half_ok;
  logic end_ok;

  assign silent_ok = result.tone_on || (result.period == 12'd0 && result.compare == 11'd0);
  assign half_ok   = result.compare == result.period[11:1];
  assign end_ok    = result.mode_now == bns_pkg::MODE_STOP && result.drive_update &&
                     !result.tone_on;

  // silence carries a zero period and compare
  `ASSERT_ALWAYS(a_silent_zero, clk, rst, !result_valid || silent_ok)

  // compare is half of the period
  `ASSERT_ALWAYS(a_half_period, clk, rst, !result_valid || half_ok)

  // end of song stops playback and silences the timer
  `ASSERT_ALWAYS(a_song_end, clk, rst, !(result_valid && result.song_done) || end_ok)

  // a stalled result holds
  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind buzzer_note_sequencer_unit bns_checker u_bns_checker (.*);

[tb/sv/tb_buzzer_note_sequencer_unit.sv]
// Self-checking bench for buzzer_note_sequencer_unit: a directed table, then random
// songs, sound loops and noise, scored against table rows or a note predictor.
// Depends on bns_pkg and the sequencer RTL.
`timescale 1ns / 100ps

module tb_buzzer_note_sequencer_unit;

  localparam int TIMER_HZ        = 1000000;
  localparam int WORD_TARGET     = 450;   // words sent before the run winds down
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
  localparam int WATCHDOG_CYCLES = 2000;  // cycles with no handshake at all

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  bns_pkg::bns_item_t   item;
  logic                 result_valid;
  logic                 result_stall;
  bns_pkg::bns_result_t result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [8:0]           cfg_data;

  buzzer_note_sequencer_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Note predictor: private copy of the sequencer state
  // ---------------------------------------------------------------------------
  logic [15:0] melody_mem [bns_pkg::PATTERN_DEPTH];
  bit          melody_set [bns_pkg::PATTERN_DEPTH];  // entry loaded at least once
  logic [8:0]  length_reg;
  logic [1:0]  cur_mode;
  int          cur_pos;
  int          cur_tick;

  bns_pkg::bns_result_t drive_q [$];  // expected result words, oldest first

  // run bookkeeping
  int  mismatches;
  int  checked;
  int  played;
  int  length_writes;
  int  songs_ended;
  int  quiet_cycles;
  bit  no_gaps;      // sender offers back to back
  bit  rx_quiet;     // receiver never stalls
  int  holds_asked;  // long hold-offs requested by the sender side
  int  holds_done;   // long hold-offs served by the receiver

  function automatic int eff_length();
    int n;
    n = int'(length_reg);
    if (n == 0) n = 1;
    if (n > bns_pkg::PATTERN_DEPTH) n = bns_pkg::PATTERN_DEPTH;
    return n;
  endfunction

  function automatic int note_hz(input int oct, input int note);
    case (oct * 7 + note - 1)
      0: return 262;   1: return 294;   2: return 330;   3: return 349;
      4: return 392;   5: return 440;   6: return 494;
      7: return 523;   8: return 587;   9: return 659;  10: return 698;
      11: return 784;  12: return 880;  13: return 988;
      14: return 1046; 15: return 1175; 16: return 1318; 17: return 1397;
      18: return 1568; 19: return 1760; 20: return 1976;
      default: return 0;
    endcase
  endfunction

  function automatic bns_pkg::bns_result_t tone_word(input int hz);
    bns_pkg::bns_result_t r;
    int p;
    r = '0;
    p = TIMER_HZ / hz - 1;
    if (p > 4095) p = 4095;
    r.drive_update = 1'b1;
    r.tone_on      = 1'b1;
    r.period       = p[11:0];
    r.compare      = p[11:1];
    return r;
  endfunction

  function automatic bns_pkg::bns_result_t silent_word();
    bns_pkg::bns_result_t r;
    r = '0;
    r.drive_update = 1'b1;
    return r;
  endfunction

  // step to the next pattern entry; a song that runs off the end stops
  function automatic void next_entry(input bit is_song, inout bns_pkg::bns_result_t r);
    cur_tick = 1;
    cur_pos++;
    if (cur_pos >= eff_length()) begin
      cur_pos = 0;
      if (is_song) begin
        cur_mode    = bns_pkg::MODE_STOP;
        r           = silent_word();
        r.song_done = 1'b1;
      end
    end
  endfunction

  function automatic bns_pkg::bns_result_t play_word(input bns_pkg::bns_item_t w);
    bns_pkg::bns_result_t r;
    logic [15:0] pw;
    int on_t, off_t, oct, note, dur;
    r  = '0;
    pw = melody_mem[cur_pos[7:0]];
    case (w.cmd)
      bns_pkg::CMD_TICK: begin
        if (cur_mode == bns_pkg::MODE_BOOT || cur_mode == bns_pkg::MODE_SONG) begin
          off_t = int'(pw[15:12]);
          on_t  = int'(pw[11:8]) * 6;
          oct   = int'(pw[7:4]);
          note  = int'(pw[3:0]);
          if (cur_tick < on_t) begin
            cur_tick++;
            // out-of-range octave or note plays as a rest
            if (oct <= 2 && note >= 1 && note <= 7) r = tone_word(note_hz(oct, note));
            else r = silent_word();
          end else if (cur_tick < on_t + off_t) begin
            cur_tick++;
            r = silent_word();
          end else begin
            next_entry(1'b1, r);
          end
        end else if (cur_mode == bns_pkg::MODE_SOUND) begin
          dur = int'(pw[7:4]) * 2;
          if (cur_tick < dur) begin
            cur_tick++;
            // unknown tone codes leave the timer alone
            case (pw[3:0])
              bns_pkg::TONE_SILENT: r = silent_word();
              bns_pkg::TONE_HIGH:   r = tone_word(640);
              bns_pkg::TONE_LOW:    r = tone_word(256);
              default:              ;
            endcase
          end else begin
            next_entry(1'b0, r);
          end
        end
      end
      bns_pkg::CMD_MODE: begin
        // the start-up song cannot be interrupted
        if (cur_mode != bns_pkg::MODE_BOOT) begin
          cur_mode = w.new_mode;
          if (w.new_mode == bns_pkg::MODE_STOP) r = silent_word();
          cur_pos  = 0;
          cur_tick = 1;
        end
      end
      bns_pkg::CMD_LOAD: begin
        melody_mem[w.load_index] = w.load_word;
        melody_set[w.load_index] = 1'b1;
      end
      default: ;
    endcase
    r.mode_now = cur_mode;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [8:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 9'($urandom_range(1, 6));
    if (r < 70) return 9'd0;
    if (r < 78) return bns_pkg::LENGTH_RESET;
    if (r < 86) return 9'd256;
    if (r < 94) return 9'h1FF;
    return 9'($urandom_range(0, 511));
  endfunction

  // mostly short, playable notes so songs finish within a phase
  function automatic logic [15:0] song_word();
    logic [3:0] off_t, on_t, oct, note;
    int r;
    r     = $urandom_range(0, 9);
    off_t = 4'($urandom_range(0, 3));
    on_t  = 4'($urandom_range(0, 2));
    oct   = 4'($urandom_range(0, 2));
    note  = 4'($urandom_range(1, 7));
    if (r == 9) return 16'($urandom);
    if (r >= 7) begin
      oct  = 4'($urandom);
      note = 4'($urandom);
    end
    return {off_t, on_t, oct, note};
  endfunction

  function automatic logic [15:0] sound_word();
    logic [7:0] hi;
    logic [3:0] dur, code;
    int r;
    hi  = 8'($urandom);
    dur = ($urandom_range(0, 9) < 9) ? 4'($urandom_range(0, 3)) : 4'($urandom);
    r   = $urandom_range(0, 9);
    if (r < 3) code = bns_pkg::TONE_SILENT;
    else if (r < 6) code = bns_pkg::TONE_HIGH;
    else if (r < 8) code = bns_pkg::TONE_LOW;
    else code = 4'($urandom);
    return {hi, dur, code};
  endfunction

  // random fields everywhere, command as given
  function automatic bns_pkg::bns_item_t item_of(input logic [1:0] cmd);
    bns_pkg::bns_item_t w;
    w.cmd        = cmd;
    w.new_mode   = 2'($urandom);
    w.load_index = 8'($urandom);
    w.load_word  = 16'($urandom);
    return w;
  endfunction

  function automatic bns_pkg::bns_item_t noisy_tick();
    if ($urandom_range(0, 99) < 85) return item_of(bns_pkg::CMD_TICK);
    return item_of(2'($urandom_range(0, 3)));
  endfunction

  // one word over the item channel; predicted at acceptance
  task automatic send_word(input bns_pkg::bns_item_t w, input bit typed,
                           input bns_pkg::bns_result_t want);
    int gap;
    bns_pkg::bns_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    r = play_word(w);
    drive_q.push_back(typed ? want : r);
    if (r.song_done) songs_ended++;
    if (w.cmd != bns_pkg::CMD_NONE) played++;
  endtask

  // keeps ticks off never-loaded entries, and keeps the locked song short
  task automatic send_item(input bns_pkg::bns_item_t w);
    bns_pkg::bns_item_t v;
    v = w;
    if (v.cmd == bns_pkg::CMD_TICK && cur_mode != bns_pkg::MODE_STOP &&
        !melody_set[cur_pos[7:0]]) begin
      v.cmd        = bns_pkg::CMD_LOAD;
      v.load_index = cur_pos[7:0];
      v.load_word  = (cur_mode == bns_pkg::MODE_SOUND) ? sound_word() : song_word();
    end
    if (v.cmd == bns_pkg::CMD_MODE && v.new_mode == bns_pkg::MODE_BOOT && eff_length() > 8)
      v.new_mode = bns_pkg::MODE_SONG;
    send_word(v, 1'b0, '0);
  endtask

  // length register: only written with nothing in flight
  task automatic write_length(input logic [8:0] len);
    item_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    length_reg = len;
    length_writes++;
  endtask

  // bring the block back to stopped
  task automatic settle();
    bns_pkg::bns_item_t w;
    while (cur_mode == bns_pkg::MODE_BOOT) send_item(item_of(bns_pkg::CMD_TICK));
    if (cur_mode != bns_pkg::MODE_STOP) begin
      w = item_of(bns_pkg::CMD_MODE);
      w.new_mode = bns_pkg::MODE_STOP;
      send_item(w);
    end
  endtask

  task automatic play_song();
    bns_pkg::bns_item_t w;
    int words, cap, i;
    words = (eff_length() <= 8) ? eff_length() : $urandom_range(2, 8);
    for (i = 0; i < words; i++) begin
      w = item_of(bns_pkg::CMD_LOAD);
      w.load_index = i[7:0];
      w.load_word  = song_word();
      send_item(w);
    end
    w = item_of(bns_pkg::CMD_MODE);
    w.new_mode = (eff_length() <= 8 && $urandom_range(0, 2) == 0) ? bns_pkg::MODE_BOOT :
                                                                   bns_pkg::MODE_SONG;
    send_item(w);
    // a locked song always runs to its end
    cap = 150;
    while (cur_mode != bns_pkg::MODE_STOP && (cur_mode == bns_pkg::MODE_BOOT || cap > 0)) begin
      cap--;
      send_item(noisy_tick());
    end
  endtask

  task automatic play_sound();
    bns_pkg::bns_item_t w;
    int words, i;
    words = $urandom_range(1, 6);
    if (words > eff_length()) words = eff_length();
    for (i = 0; i < words; i++) begin
      w = item_of(bns_pkg::CMD_LOAD);
      w.load_index = i[7:0];
      w.load_word  = sound_word();
      send_item(w);
    end
    w = item_of(bns_pkg::CMD_MODE);
    w.new_mode = bns_pkg::MODE_SOUND;
    send_item(w);
    repeat ($urandom_range(10, 50)) send_item(noisy_tick());
  endtask

  task automatic run_phase(input int phase);
    int kind;
    no_gaps  = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);
    if (phase == 0) write_length(9'd1);
    else if (phase == 1) write_length(9'h1FF);
    else if ($urandom_range(0, 2) == 0) write_length(pick_length());
    // back-to-back words into a held-off receiver to fill the pipe
    if (phase == 2 || $urandom_range(0, 19) == 0) begin
      no_gaps  = 1'b1;
      rx_quiet = 1'b0;
      holds_asked++;
    end
    kind = $urandom_range(0, 9);
    if (kind < 4) play_song();
    else if (kind < 8) play_sound();
    else repeat (20) send_item(item_of(2'($urandom_range(0, 3))));
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    bns_pkg::bns_item_t   w;
    bit                   typed;
    bns_pkg::bns_result_t want;
  } drill_t;

  drill_t drill_q [$];

  function automatic void add_row(input logic [1:0] cmd, input logic [1:0] nm,
                                  input logic [7:0] idx, input logic [15:0] word,
                                  input bit typed, input logic upd, input logic on,
                                  input logic [11:0] per, input logic [10:0] cmp,
                                  input logic [1:0] mode);
    drill_t d;
    d.w     = '{cmd: cmd, new_mode: nm, load_index: idx, load_word: word};
    d.typed = typed;
    d.want  = '{drive_update: upd, tone_on: on, period: per, compare: cmp,
                mode_now: mode, song_done: 1'b0};
    drill_q.push_back(d);
  endfunction

  function automatic void build_drill();
    // stopped: tick and unused command do nothing, stop drives silence
    add_row(bns_pkg::CMD_TICK, bns_pkg::MODE_STOP,  8'h00, 16'h0000, 1, 0, 0, 0, 0,
            bns_pkg::MODE_STOP);
    add_row(bns_pkg::CMD_NONE, bns_pkg::MODE_SOUND, 8'hFF, 16'hFFFF, 1, 0, 0, 0, 0,
            bns_pkg::MODE_STOP);
    add_row(bns_pkg::CMD_MODE, bns_pkg::MODE_STOP,  8'h00, 16'h0000, 1, 1, 0, 0, 0,
            bns_pkg::MODE_STOP);
    // sound loop: silence, 640 Hz, 256 Hz, unknown code
    add_row(bns_pkg::CMD_LOAD, bns_pkg::MODE_SOUND, 8'h00, 16'h0010, 1, 0, 0, 0, 0,
            bns_pkg::MODE_STOP);
    add_row(bns_pkg::CMD_LOAD, bns_pkg::MODE_SONG,  8'h01, 16'h002B, 1, 0, 0, 0, 0,
            bns_pkg::MODE_STOP);
    add_row(bns_pkg::CMD_LOAD, bns_pkg::MODE_BOOT,  8'h02, 16'h001D, 1, 0, 0, 0, 0,
            bns_pkg::MODE_STOP);
    add_row(bns_pkg::CMD_LOAD, bns_pkg::MODE_STOP,  8'h03, 16'hFF17, 1, 0, 0, 0, 0,
            bns_pkg::MODE_STOP);
    add_row(bns_pkg::CMD_MODE, bns_pkg::MODE_SOUND, 8'hA5, 16'h5A5A, 1, 0, 0, 0, 0,
            bns_pkg::MODE_SOUND);
    repeat (10) add_row(bns_pkg::CMD_TICK, bns_pkg::MODE_STOP, 8'h00, 16'h0000, 0, 0, 0, 0,
                        0, bns_pkg::MODE_STOP);
    // top address, then a song: lowest note, invalid note mid-play
    add_row(bns_pkg::CMD_LOAD, bns_pkg::MODE_STOP,  8'h00, 16'h0101, 1, 0, 0, 0, 0,
            bns_pkg::MODE_SOUND);
    add_row(bns_pkg::CMD_LOAD, bns_pkg::MODE_STOP,  8'hFF, 16'hFFFF, 1, 0, 0, 0, 0,
            bns_pkg::MODE_SOUND);
    add_row(bns_pkg::CMD_MODE, bns_pkg::MODE_SONG,  8'h00, 16'h0000, 1, 0, 0, 0, 0,
            bns_pkg::MODE_SONG);
    add_row(bns_pkg::CMD_TICK, bns_pkg::MODE_STOP,  8'h00, 16'h0000, 1, 1, 1, 3815, 1907,
            bns_pkg::MODE_SONG);
    add_row(bns_pkg::CMD_LOAD, bns_pkg::MODE_STOP,  8'h00, 16'h01F8, 1, 0, 0, 0, 0,
            bns_pkg::MODE_SONG);
    add_row(bns_pkg::CMD_TICK, bns_pkg::MODE_STOP,  8'h00, 16'h0000, 0, 0, 0, 0, 0,
            bns_pkg::MODE_STOP);
    // locked start-up song ignores a stop request
    add_row(bns_pkg::CMD_MODE, bns_pkg::MODE_BOOT,  8'h00, 16'h0000, 1, 0, 0, 0, 0,
            bns_pkg::MODE_BOOT);
    add_row(bns_pkg::CMD_MODE, bns_pkg::MODE_STOP,  8'h00, 16'h0000, 1, 0, 0, 0, 0,
            bns_pkg::MODE_BOOT);
    add_row(bns_pkg::CMD_TICK, bns_pkg::MODE_STOP,  8'h00, 16'h0000, 0, 0, 0, 0, 0,
            bns_pkg::MODE_STOP);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: scoring and receiver stalls
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [11:0] want,
                             input logic [11:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : score
    bns_pkg::bns_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (drive_q.size() == 0) begin
        $display("%0t ns: result word %h with nothing pending", $time, result);
        mismatches++;
      end else begin
        want = drive_q.pop_front();
        checked++;
        check_field("drive_update", 12'(want.drive_update), 12'(result.drive_update));
        check_field("tone_on",      12'(want.tone_on),      12'(result.tone_on));
        check_field("period",       want.period,            result.period);
        check_field("compare",      12'(want.compare),      12'(result.compare));
        check_field("mode_now",     12'(want.mode_now),     12'(result.mode_now));
        check_field("song_done",    12'(want.song_done),    12'(result.song_done));
      end
    end
  end

  // stall pattern: mostly short bursts, now and then a long one
  initial begin : receiver
    int r;
    holds_done = 0;
    result_stall <= 1'b0;
    forever begin
      if (holds_done != holds_asked) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done = holds_asked;
      end else if (rx_quiet) begin
        result_stall <= 1'b0;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          result_stall <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end else if (r < 95) begin
          result_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          result_stall <= 1'b1;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  // watchdog: any handshake resets it
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t ns: no handshake for %0d cycles", $time, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    int phase, i;
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    item         <= '0;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    played       = 0;
    length_writes = 0;
    songs_ended  = 0;
    no_gaps      = 1'b0;
    rx_quiet     = 1'b0;
    holds_asked  = 0;
    foreach (melody_set[k]) melody_set[k] = 1'b0;
    length_reg = bns_pkg::LENGTH_RESET;
    cur_mode   = bns_pkg::MODE_STOP;
    cur_pos    = 0;
    cur_tick   = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part runs at the reset pattern length
    build_drill();
    for (i = 0; i < drill_q.size(); i++)
      send_word(drill_q[i].w, drill_q[i].typed, drill_q[i].want);

    // random part: finish the locked song first, then mixed phases
    settle();
    phase = 0;
    while (played < WORD_TARGET) begin
      run_phase(phase);
      phase++;
    end

    // drain; the watchdog bounds this wait
    item_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("Sent %0d words over %0d phases, %0d length writes, %0d songs played out.",
             played, phase, length_writes, songs_ended);
    $display("Scored %0d result words, %0d mismatches.", checked, mismatches);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/bns_pkg.sv
sv/bns_ram.sv
sv/bns_step.sv
sv/buzzer_note_sequencer_unit.sv
sv/bns_checker.sv
tb/sv/tb_buzzer_note_sequencer_unit.sv
